[rtl/core/bcg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button gesture classifier package
// Shared widths, gesture codes, register indexes and the state record.
// ----------------------------------------------------------------------------
package bcg_pkg;

    localparam int TICK_W      = 16;
    localparam int CLICK_W     = 8;
    localparam int GESTURE_W   = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int TDATA_W     = 8;

    localparam logic [TICK_W-1:0] LONG_PRESS_RESET   = 16'd200;
    localparam logic [TICK_W-1:0] CLICK_WINDOW_RESET = 16'd100;

    localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};
    localparam logic [CLICK_W-1:0] CLICK_MAX = {CLICK_W{1'b1}};

    localparam logic [GESTURE_W-1:0] GESTURE_NONE   = 2'd0;
    localparam logic [GESTURE_W-1:0] GESTURE_SINGLE = 2'd1;
    localparam logic [GESTURE_W-1:0] GESTURE_MULTI  = 2'd2;
    localparam logic [GESTURE_W-1:0] GESTURE_LONG   = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CLICK_WINDOW = 8'd1;

    typedef struct packed {
        logic               was_pressed;
        logic               long_fired;
        logic [TICK_W-1:0]  hold_ticks;
        logic [CLICK_W-1:0] click_total;
        logic [TICK_W-1:0]  window_ticks;
    } bcg_state_t;

endpackage

[rtl/core/button_click_gesture_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button click gesture classifier
// Turns a stream of button samples into single, multi and long-press events.
// ----------------------------------------------------------------------------
// Usage: each slave-side transaction carries one sample tick of the button
// level in s_tdata bit 0. For every tick exactly one master-side transaction
// follows, whose m_tdata holds the gesture code: none, single click, multi
// click or long press. The thresholds are written through the cfg channel
// (index 0: long-press ticks, index 1: click-window ticks); unknown indexes
// are ignored and cfg_ready is always high. Write them only while idle.
// The result of an accepted tick is written into the output register at the
// same edge that accepts it. Throughput is one tick per cycle, set by the
// single output register, which is refilled in the same cycle that its
// contents are taken. When the receiver stalls, the held result stays on
// m_tdata and s_tready drops until it is taken, so no result is lost.
// Reset clears the gesture state, empties the output register and restores
// the default thresholds of 200 and 100 ticks.
// ----------------------------------------------------------------------------
module button_click_gesture_classifier
    import bcg_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,    // [0] pressed, [7:1] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,    // [1:0] gesture, [7:2] zero
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    bcg_state_t             state_reg;
    bcg_state_t             state_next;
    logic [TICK_W-1:0]      long_press_reg;
    logic [TICK_W-1:0]      click_window_reg;
    logic                   m_tvalid_reg;
    logic [GESTURE_W-1:0]   gesture_reg;
    logic [GESTURE_W-1:0]   gesture_next;
    logic                   s_fire;

    // The output register can take a new result whenever it is empty or is
    // being emptied in this cycle.
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(TDATA_W-GESTURE_W){1'b0}}, gesture_reg};

    bcg_step u_step
    (
        .state              (state_reg),
        .pressed            (s_tdata[0]),
        .long_press_ticks   (long_press_reg),
        .click_window_ticks (click_window_reg),
        .state_next         (state_next),
        .gesture            (gesture_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_press_reg   <= LONG_PRESS_RESET;
            click_window_reg <= CLICK_WINDOW_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LONG_PRESS:   long_press_reg   <= cfg_data;
                REG_CLICK_WINDOW: click_window_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Gesture state advances only on an accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (s_fire)
            begin
                state_reg    <= state_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            gesture_reg <= gesture_next;
        end
    end

    // A reported long press leaves no clicks pending until its release.
    a_long_no_clicks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.long_fired |-> (state_reg.click_total == '0))
        else $error("clicks pending while a long press is held");

    // The window timer only runs while clicks are pending.
    a_window_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.click_total == '0) |-> (state_reg.window_ticks == '0))
        else $error("click window running with no clicks pending");

    // A long press can only be on record while the button is held.
    a_long_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.long_fired |-> state_reg.was_pressed)
        else $error("long press flag set with the button released");

    // A released tick clears the hold.
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && !s_tdata[0]) |=> (!state_reg.was_pressed && state_reg.hold_ticks == '0))
        else $error("hold state not cleared on release");

endmodule

[rtl/core/bcg_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button gesture classifier step logic
// Works out the next gesture state and the gesture code for one tick.
// ----------------------------------------------------------------------------
module bcg_step
    import bcg_pkg::*;
(
    input  bcg_state_t               state,
    input  logic                     pressed,
    input  logic [TICK_W-1:0]        long_press_ticks,
    input  logic [TICK_W-1:0]        click_window_ticks,
    output bcg_state_t               state_next,
    output logic [GESTURE_W-1:0]     gesture
);

    logic [TICK_W-1:0]  hold_start;
    logic [TICK_W-1:0]  hold_inc;
    logic [CLICK_W-1:0] click_mid;
    logic [TICK_W-1:0]  window_mid;
    logic [TICK_W-1:0]  window_inc;
    logic               long_mid;
    logic               fire;

    always_comb
    begin
        hold_start = (pressed && !state.was_pressed) ? '0 : state.hold_ticks;
        hold_inc   = (hold_start == TICK_MAX) ? hold_start : hold_start + 1'b1;
        fire       = pressed && (hold_inc >= long_press_ticks) && !state.long_fired;

        gesture    = GESTURE_NONE;
        long_mid   = state.long_fired;
        click_mid  = state.click_total;
        window_mid = state.window_ticks;

        state_next.was_pressed = pressed;
        state_next.hold_ticks  = pressed ? hold_inc : '0;

        if (pressed)
        begin
            if (fire)
            begin
                gesture    = GESTURE_LONG;
                long_mid   = 1'b1;
                click_mid  = '0;
                window_mid = '0;
            end
        end
        else if (state.was_pressed)
        begin
            // A release after a long press wipes the gesture; otherwise it is a click.
            if (!state.long_fired)
            begin
                if (state.click_total != CLICK_MAX)
                begin
                    click_mid = state.click_total + 1'b1;
                end
                window_mid = '0;
            end
            else
            begin
                long_mid   = 1'b0;
                click_mid  = '0;
                window_mid = '0;
            end
        end

        window_inc = (window_mid == TICK_MAX) ? window_mid : window_mid + 1'b1;

        state_next.long_fired   = long_mid;
        state_next.click_total  = click_mid;
        state_next.window_ticks = window_mid;

        if (click_mid != '0)
        begin
            if (window_inc >= click_window_ticks)
            begin
                gesture = (click_mid == CLICK_W'(1)) ? GESTURE_SINGLE : GESTURE_MULTI;
                state_next.click_total  = '0;
                state_next.window_ticks = '0;
            end
            else
            begin
                state_next.window_ticks = window_inc;
            end
        end
    end

endmodule
